### rtl/omfp_pkg.sv
// Shared types, constants and helpers for the orientation matrix block.
// No dependencies; every other file in rtl/ except omfp_if.sv imports this package.
package omfp_pkg;

	// element format: Q1.14
	localparam int ELEM_FRAC_BITS = 14;
	localparam logic [14:0] ONE_Q = 15'd16384;
	localparam logic [28:0] ONE_SQ = 29'h1000_0000;
	localparam logic [30:0] HALF_LSB = 31'd8192;

	// integer square root: 32 result bits, two per stage
	localparam int SQ_STEPS = 2;
	localparam int SQ_STAGES = 32 / SQ_STEPS;
	// divider: one setup stage, then 16 quotient bits, two per stage
	localparam int DIV_STEPS = 2;
	localparam int DIV_STAGES = 16 / DIV_STEPS;
	localparam int DIV_LAT = 1 + DIV_STAGES;

	localparam logic [1:0] LAST_ROW = 2'd3;

	typedef logic [15:0] elem_t;
	typedef logic [3:0][15:0] row_t;

	// flags and side data that ride along with the arithmetic
	typedef struct packed {
		logic        vld;
		logic        degen;
		logic        sy_neg;
		logic        sz_neg;
		logic        cz_neg;
		logic [30:0] ny;
		logic [30:0] nz;
		logic [14:0] sy_m;
		logic [14:0] sz_m;
		logic [14:0] cy_m;
		logic [14:0] cz_m;
	} sb_t;

	// apply a sign to a Q1.14 magnitude
	function automatic elem_t sgn16(input logic neg, input logic [14:0] mag);
		elem_t v;
		v = {1'b0, mag};
		return neg ? elem_t'(-v) : v;
	endfunction

	// round a Q2.28 product to Q1.14, ties away from zero on magnitudes
	function automatic logic [14:0] qround(input logic [29:0] p);
		logic [30:0] s;
		s = {1'b0, p} + HALF_LSB;
		return s[28:14];
	endfunction

endpackage

### rtl/omfp_if.sv
// Handshake channels of the orientation matrix block: point pairs in, rows out.
// Depends on no other file; the row elements are plain 16-bit signed vectors.
interface omfp_pts_if;
	logic               valid;
	logic               ready;
	logic signed [31:0] from_x;
	logic signed [31:0] from_y;
	logic signed [31:0] from_z;
	logic signed [31:0] to_x;
	logic signed [31:0] to_y;
	logic signed [31:0] to_z;

	modport source (output valid, from_x, from_y, from_z, to_x, to_y, to_z, input ready);
	modport sink (input valid, from_x, from_y, from_z, to_x, to_y, to_z, output ready);
endinterface

interface omfp_row_if;
	logic               valid;
	logic               ready;
	logic [1:0]         row_index;
	logic signed [15:0] elem_0;
	logic signed [15:0] elem_1;
	logic signed [15:0] elem_2;
	logic signed [15:0] elem_3;
	logic               last_row;
	logic               degenerate;

	modport source (output valid, row_index, elem_0, elem_1, elem_2, elem_3, last_row,
		degenerate, input ready);
	modport sink (input valid, row_index, elem_0, elem_1, elem_2, elem_3, last_row,
		degenerate, output ready);
endinterface

### rtl/omfp_isqrt.sv
// Pipelined integer square root of a 64-bit value, floor root plus remainder.
// Depends on omfp_pkg for the stage count; advances only when en is high.
module omfp_isqrt (
	input  logic        clk,
	input  logic        en,
	input  logic [63:0] rad,
	output logic [31:0] root,
	output logic [32:0] rem
);
	import omfp_pkg::*;

	typedef struct packed {
		logic [63:0] x;
		logic [34:0] r;
		logic [31:0] q;
	} sq_t;

	sq_t pipe_s [SQ_STAGES];
	sq_t nxt [SQ_STAGES];

	// one digit: bring down two radicand bits, try root*4+1
	function automatic sq_t sq_step(input sq_t a);
		sq_t b;
		logic [34:0] t;
		logic [34:0] tr;
		t = {a.r[32:0], a.x[63:62]};
		tr = {1'b0, a.q, 2'b01};
		b.x = {a.x[61:0], 2'b00};
		if (t >= tr) begin
			b.r = t - tr;
			b.q = {a.q[30:0], 1'b1};
		end else begin
			b.r = t;
			b.q = {a.q[30:0], 1'b0};
		end
		return b;
	endfunction

	for (genvar i = 0; i < SQ_STAGES; i++) begin : g_stage
		always_comb begin
			sq_t a;
			if (i == 0) begin
				a.x = rad;
				a.r = '0;
				a.q = '0;
			end else begin
				a = pipe_s[i-1];
			end
			for (int k = 0; k < SQ_STEPS; k++)
				a = sq_step(a);
			nxt[i] = a;
		end

		always_ff @(posedge clk) begin
			if (en)
				pipe_s[i] <= nxt[i];
		end
	end

	assign root = pipe_s[SQ_STAGES-1].q;
	assign rem = pipe_s[SQ_STAGES-1].r[32:0];

endmodule

### rtl/omfp_div.sv
// Pipelined rounded ratio (num * 2^14 + den/2) / den, 16 quotient bits.
// Depends on omfp_pkg; num must not exceed den so the quotient fits.
module omfp_div (
	input  logic        clk,
	input  logic        en,
	input  logic [30:0] num,
	input  logic [31:0] den,
	output logic [15:0] quo
);
	import omfp_pkg::*;

	typedef struct packed {
		logic [15:0] n;
		logic [31:0] r;
		logic [15:0] q;
		logic [31:0] d;
	} dv_t;

	logic [45:0] dvd;
	dv_t         init_s0;
	dv_t         pipe_s [DIV_STAGES];
	dv_t         nxt [DIV_STAGES];

	// one restoring step
	function automatic dv_t dv_step(input dv_t a);
		dv_t b;
		logic [32:0] t;
		t = {a.r, a.n[15]};
		b.n = {a.n[14:0], 1'b0};
		b.d = a.d;
		if (t >= {1'b0, a.d}) begin
			b.r = 32'(t - {1'b0, a.d});
			b.q = {a.q[14:0], 1'b1};
		end else begin
			b.r = t[31:0];
			b.q = {a.q[14:0], 1'b0};
		end
		return b;
	endfunction

	// setup: form the rounded dividend
	assign dvd = {1'b0, num, 14'd0} + {15'd0, den[31:1]};

	always_ff @(posedge clk) begin
		if (en) begin
			init_s0.n <= dvd[15:0];
			init_s0.r <= {2'b00, dvd[45:16]};
			init_s0.q <= '0;
			init_s0.d <= den;
		end
	end

	for (genvar i = 0; i < DIV_STAGES; i++) begin : g_stage
		always_comb begin
			dv_t a;
			a = (i == 0) ? init_s0 : pipe_s[i-1];
			for (int k = 0; k < DIV_STEPS; k++)
				a = dv_step(a);
			nxt[i] = a;
		end

		always_ff @(posedge clk) begin
			if (en)
				pipe_s[i] <= nxt[i];
		end
	end

	assign quo = pipe_s[DIV_STAGES-1].q;

endmodule

### rtl/orientation_matrix_from_points.sv
// Orientation matrix from two points. Each accepted word (points p and q, Q16.16) yields
// four row words of the rotation matrix that turns the x axis toward q - p, elements in
// Q1.14, row 0 first; coinciding points give the identity with degenerate set. A new point
// word is taken only while the output buffer is empty or its last row is leaving: the row
// port moves one row a cycle while ready is high, and the whole pipeline holds while the
// four-row output buffer is still occupied.
// Depends on omfp_pkg, omfp_if, omfp_isqrt and omfp_div.
module orientation_matrix_from_points (
	input  logic clk,
	input  logic arst_n,
	omfp_pts_if.sink   pts,
	omfp_row_if.source rows
);
	import omfp_pkg::*;

	logic en;

	// stage 1: differences
	logic               vld_s1;
	logic signed [32:0] dx_s1, dy_s1, dz_s1;
	// stage 2: magnitudes and sign flags
	logic [32:0] ax_s2, ay_s2, az_s2;
	sb_t         fl_s2;
	// stage 3: largest magnitude
	logic [32:0] ax_s3, ay_s3, az_s3, mx_s3;
	sb_t         fl_s3;
	// stage 4: normalizing shift
	logic [32:0] ax_s4, ay_s4, az_s4;
	logic        big_s4;
	logic [4:0]  sh_s4;
	sb_t         fl_s4;
	logic [4:0]  msb;
	// stage 5: normalized magnitudes
	logic [30:0] nx_s5;
	sb_t         fl_s5;
	// stage 6: squares
	logic [61:0] qx_s6, qy_s6, qz_s6;
	sb_t         fl_s6;
	// stage 7: sum of squares
	logic [63:0] sum_s7;
	sb_t         fl_s7;
	// root, ratio and cosine roots
	logic [31:0] root_l;
	logic [32:0] rem_l;
	sb_t         dl1_s [SQ_STAGES];
	logic [15:0] quo_y, quo_z;
	sb_t         dl2_s [DIV_LAT];
	sb_t         fl_s8;
	logic [28:0] argy_s9, argz_s9;
	sb_t         fl_s9;
	logic [29:0] sqy, sqz;
	logic [31:0] rty, rtz;
	logic [32:0] rmy, rmz;
	sb_t         dl3_s [SQ_STAGES];
	sb_t         fl_s10;
	// next values of the side data where a stage fills in fields
	sb_t         fl_n2, fl_n5, fl_n8, fl_n10;
	// stage 11: products
	logic [29:0] p00_s11, p01_s11, p20_s11, p21_s11;
	sb_t         fl_s11;
	// stage 12: rows
	row_t        rows_s12 [4];
	logic        vld_s12, deg_s12;
	row_t        row_n [4];
	logic [14:0] m00, m01, m20, m21;
	// output buffer
	row_t        rows_q [4];
	logic        full_q, deg_q;
	logic [1:0]  cnt_q;

	// whole pipeline moves when the row buffer can take a matrix
	assign en = !full_q || (rows.ready && cnt_q == LAST_ROW);
	assign pts.ready = en;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (en) begin
			vld_s1 <= pts.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			dx_s1 <= 33'(pts.to_x) - 33'(pts.from_x);
			dy_s1 <= 33'(pts.to_y) - 33'(pts.from_y);
			dz_s1 <= 33'(pts.to_z) - 33'(pts.from_z);
		end
	end

	// side data filled in at the flag, shift, ratio and cosine stages
	always_comb begin
		fl_n2 = '0;
		fl_n2.vld = vld_s1;
		fl_n2.degen = (dx_s1 == '0) && (dy_s1 == '0) && (dz_s1 == '0);
		fl_n2.sy_neg = !dz_s1[32] && (dz_s1 != '0);
		fl_n2.sz_neg = dy_s1[32];
		fl_n2.cz_neg = dx_s1[32] || (dx_s1 == '0);

		fl_n5 = fl_s4;
		if (big_s4) begin
			fl_n5.ny = ay_s4[31:1];
			fl_n5.nz = az_s4[31:1];
		end else begin
			fl_n5.ny = ay_s4[30:0] << sh_s4;
			fl_n5.nz = az_s4[30:0] << sh_s4;
		end

		fl_n8 = dl2_s[DIV_LAT-1];
		fl_n8.sy_m = (quo_z > {1'b0, ONE_Q}) ? ONE_Q : quo_z[14:0];
		fl_n8.sz_m = (quo_y > {1'b0, ONE_Q}) ? ONE_Q : quo_y[14:0];

		fl_n10 = dl3_s[SQ_STAGES-1];
		fl_n10.cy_m = rty[14:0] + 15'((rmy > {1'b0, rty}) ? 1 : 0);
		fl_n10.cz_m = rtz[14:0] + 15'((rmz > {1'b0, rtz}) ? 1 : 0);
	end

	// magnitudes and signs of the direction
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fl_s2 <= '0;
			fl_s3 <= '0;
			fl_s4 <= '0;
			fl_s5 <= '0;
			fl_s6 <= '0;
			fl_s7 <= '0;
		end else if (en) begin
			fl_s2 <= fl_n2;
			fl_s3 <= fl_s2;
			fl_s4 <= fl_s3;
			fl_s5 <= fl_n5;
			fl_s6 <= fl_s5;
			fl_s7 <= fl_s6;
		end
	end

	// highest set bit of the largest magnitude
	always_comb begin
		msb = '0;
		for (int i = 0; i < 31; i++)
			if (mx_s3[i])
				msb = 5'(i);
	end

	always_ff @(posedge clk) begin
		if (en) begin
			ax_s2 <= dx_s1[32] ? 33'(-dx_s1) : 33'(dx_s1);
			ay_s2 <= dy_s1[32] ? 33'(-dy_s1) : 33'(dy_s1);
			az_s2 <= dz_s1[32] ? 33'(-dz_s1) : 33'(dz_s1);
			ax_s3 <= ax_s2;
			ay_s3 <= ay_s2;
			az_s3 <= az_s2;
			if (ax_s2 >= ay_s2 && ax_s2 >= az_s2)
				mx_s3 <= ax_s2;
			else if (ay_s2 >= az_s2)
				mx_s3 <= ay_s2;
			else
				mx_s3 <= az_s2;
			ax_s4 <= ax_s3;
			ay_s4 <= ay_s3;
			az_s4 <= az_s3;
			big_s4 <= mx_s3[32] || mx_s3[31];
			sh_s4 <= 5'd30 - msb;
			nx_s5 <= big_s4 ? ax_s4[31:1] : ax_s4[30:0] << sh_s4;
			qx_s6 <= nx_s5 * nx_s5;
			qy_s6 <= fl_s5.ny * fl_s5.ny;
			qz_s6 <= fl_s5.nz * fl_s5.nz;
			sum_s7 <= {2'b00, qx_s6} + {2'b00, qy_s6} + {2'b00, qz_s6};
		end
	end

	// length of the normalized direction
	omfp_isqrt u_len (
		.clk  (clk),
		.en   (en),
		.rad  (sum_s7),
		.root (root_l),
		.rem  (rem_l)
	);

	// sines as ratios to the length
	omfp_div u_div_y (
		.clk (clk),
		.en  (en),
		.num (dl1_s[SQ_STAGES-1].ny),
		.den (root_l),
		.quo (quo_y)
	);

	omfp_div u_div_z (
		.clk (clk),
		.en  (en),
		.num (dl1_s[SQ_STAGES-1].nz),
		.den (root_l),
		.quo (quo_z)
	);

	// cosine radicands
	assign sqy = fl_s8.sy_m * fl_s8.sy_m;
	assign sqz = fl_s8.sz_m * fl_s8.sz_m;

	omfp_isqrt u_cos_y (
		.clk  (clk),
		.en   (en),
		.rad  ({35'd0, argy_s9}),
		.root (rty),
		.rem  (rmy)
	);

	omfp_isqrt u_cos_z (
		.clk  (clk),
		.en   (en),
		.rad  ({35'd0, argz_s9}),
		.root (rtz),
		.rem  (rmz)
	);

	// side data delay lines matching the root, divider and cosine latencies
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < SQ_STAGES; i++) begin
				dl1_s[i] <= '0;
				dl3_s[i] <= '0;
			end
			for (int i = 0; i < DIV_LAT; i++)
				dl2_s[i] <= '0;
			fl_s8 <= '0;
			fl_s9 <= '0;
			fl_s10 <= '0;
			fl_s11 <= '0;
		end else if (en) begin
			dl1_s[0] <= fl_s7;
			dl3_s[0] <= fl_s9;
			for (int i = 1; i < SQ_STAGES; i++) begin
				dl1_s[i] <= dl1_s[i-1];
				dl3_s[i] <= dl3_s[i-1];
			end
			dl2_s[0] <= dl1_s[SQ_STAGES-1];
			for (int i = 1; i < DIV_LAT; i++)
				dl2_s[i] <= dl2_s[i-1];
			fl_s8 <= fl_n8;
			fl_s9 <= fl_s8;
			fl_s10 <= fl_n10;
			fl_s11 <= fl_s10;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			argy_s9 <= ONE_SQ - sqy[28:0];
			argz_s9 <= ONE_SQ - sqz[28:0];
			p00_s11 <= fl_s10.cy_m * fl_s10.cz_m;
			p01_s11 <= fl_s10.cy_m * fl_s10.sz_m;
			p20_s11 <= fl_s10.sy_m * fl_s10.cz_m;
			p21_s11 <= fl_s10.sy_m * fl_s10.sz_m;
		end
	end

	// assemble the four rows
	assign m00 = qround(p00_s11);
	assign m01 = qround(p01_s11);
	assign m20 = qround(p20_s11);
	assign m21 = qround(p21_s11);

	always_comb begin
		for (int i = 0; i < 4; i++)
			row_n[i] = '0;
		if (fl_s11.degen) begin
			for (int i = 0; i < 4; i++)
				row_n[i][i] = {1'b0, ONE_Q};
		end else begin
			row_n[0][0] = sgn16(fl_s11.cz_neg, m00);
			row_n[0][1] = sgn16(fl_s11.sz_neg, m01);
			row_n[0][2] = sgn16(!fl_s11.sy_neg, fl_s11.sy_m);
			row_n[1][0] = sgn16(!fl_s11.sz_neg, fl_s11.sz_m);
			row_n[1][1] = sgn16(fl_s11.cz_neg, fl_s11.cz_m);
			row_n[2][0] = sgn16(fl_s11.sy_neg ^ fl_s11.cz_neg, m20);
			row_n[2][1] = sgn16(fl_s11.sy_neg ^ fl_s11.sz_neg, m21);
			row_n[2][2] = sgn16(1'b0, fl_s11.cy_m);
			row_n[3][3] = {1'b0, ONE_Q};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s12 <= 1'b0;
		end else if (en) begin
			vld_s12 <= fl_s11.vld;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			rows_s12 <= row_n;
			deg_s12 <= fl_s11.degen;
		end
	end

	// output buffer: one matrix, sent a row per word
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			full_q <= 1'b0;
			cnt_q <= '0;
		end else if (en) begin
			full_q <= vld_s12;
			cnt_q <= '0;
		end else if (rows.ready) begin
			cnt_q <= cnt_q + 2'd1;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			rows_q <= rows_s12;
			deg_q <= deg_s12;
		end
	end

	assign rows.valid = full_q;
	assign rows.row_index = cnt_q;
	assign rows.elem_0 = rows_q[cnt_q][0];
	assign rows.elem_1 = rows_q[cnt_q][1];
	assign rows.elem_2 = rows_q[cnt_q][2];
	assign rows.elem_3 = rows_q[cnt_q][3];
	assign rows.last_row = (cnt_q == LAST_ROW);
	assign rows.degenerate = deg_q;

endmodule

### dv/orientation_matrix_from_points_tb.sv
// Self-checking testbench for orientation_matrix_from_points: random and directed point pairs,
// predicted rows compared field by field. Depends on omfp_pkg, omfp_if and the block's RTL.
`timescale 1ns / 100ps

module orientation_matrix_from_points_tb;
	import omfp_pkg::*;

	localparam longint ONE = 64'sd1 << ELEM_FRAC_BITS;
	localparam int CYCLE_LIMIT = 400000;

	typedef struct {
		logic signed [31:0] fx, fy, fz, tx, ty, tz;
	} pair_t;

	typedef struct {
		logic [1:0]  row_index;
		logic [15:0] e0, e1, e2, e3;
		logic        last_row;
		logic        degenerate;
	} row_word_t;

	logic clk;
	logic arst_n;

	omfp_pts_if pts ();
	omfp_row_if rows ();

	orientation_matrix_from_points dut (
		.clk(clk),
		.arst_n(arst_n),
		.pts(pts),
		.rows(rows)
	);

	pair_t     pair_q[$];
	row_word_t row_exp_q[$];
	int        errors = 0;
	int        rows_seen = 0;
	int        pairs_sent = 0;
	int        degen_seen = 0;
	int        cycles = 0;
	bit        hold_rows = 0;
	bit        stim_done = 0;
	bit        pts_taken = 0;

	// clock
	initial begin
		clk = 0;
		forever #6 clk = ~clk;
	end

	// bitwise integer square root, floor
	function automatic longint unsigned isqrt_floor(input longint unsigned x);
		longint unsigned r, b;
		r = 0;
		b = 64'd1 << 62;
		while (b > x) b >>= 2;
		while (b != 0) begin
			if (x >= r + b) begin
				x -= r + b;
				r = (r >> 1) + b;
			end else begin
				r >>= 1;
			end
			b >>= 2;
		end
		return r;
	endfunction

	function automatic longint sqrt_nearest(input longint unsigned x);
		longint unsigned r;
		r = isqrt_floor(x);
		if (x - r * r > r) r++;
		return longint'(r);
	endfunction

	// Q1.14 product, ties away from zero
	function automatic longint fix_mul(input longint a, input longint b);
		bit neg;
		longint unsigned ma, mb, p;
		neg = (a < 0) != (b < 0);
		ma = (a < 0) ? -a : a;
		mb = (b < 0) ? -b : b;
		p = (ma * mb + (64'd1 << (ELEM_FRAC_BITS - 1))) >> ELEM_FRAC_BITS;
		return neg ? -longint'(p) : longint'(p);
	endfunction

	function automatic longint unit_frac(input longint unsigned num, input longint unsigned root);
		longint unsigned v;
		v = ((num << ELEM_FRAC_BITS) + (root >> 1)) / root;
		if (v > ONE) v = ONE;
		return longint'(v);
	endfunction

	// expected rows of the orientation matrix for one point pair
	task automatic push_matrix_rows(input pair_t p);
		longint dx, dy, dz, sy, sz, cy, cz;
		longint unsigned ax, ay, az, mx, root;
		longint m[4][4];
		bit degen;
		row_word_t w;
		dx = longint'(p.tx) - longint'(p.fx);
		dy = longint'(p.ty) - longint'(p.fy);
		dz = longint'(p.tz) - longint'(p.fz);
		for (int i = 0; i < 4; i++)
			for (int j = 0; j < 4; j++) m[i][j] = (i == j) ? ONE : 0;
		degen = (dx == 0 && dy == 0 && dz == 0);
		if (!degen) begin
			ax = dx < 0 ? -dx : dx;
			ay = dy < 0 ? -dy : dy;
			az = dz < 0 ? -dz : dz;
			mx = ax;
			if (ay > mx) mx = ay;
			if (az > mx) mx = az;
			// common normalization into [2^30, 2^31)
			if (mx >= (64'd1 << 31)) begin
				ax >>= 1; ay >>= 1; az >>= 1;
			end else begin
				while (mx < (64'd1 << 30)) begin
					mx <<= 1; ax <<= 1; ay <<= 1; az <<= 1;
				end
			end
			root = isqrt_floor(ax * ax + ay * ay + az * az);
			sy = unit_frac(az, root);
			if (dz > 0) sy = -sy;
			sz = unit_frac(ay, root);
			if (dy < 0) sz = -sz;
			cy = sqrt_nearest(ONE * ONE - sy * sy);
			cz = sqrt_nearest(ONE * ONE - sz * sz);
			if (!(dx > 0)) cz = -cz;
			m[0][0] = fix_mul(cy, cz);
			m[0][1] = fix_mul(cy, sz);
			m[0][2] = -sy;
			m[1][0] = -sz;
			m[1][1] = cz;
			m[1][2] = 0;
			m[2][0] = fix_mul(sy, cz);
			m[2][1] = fix_mul(sy, sz);
			m[2][2] = cy;
		end
		for (int i = 0; i < 4; i++) begin
			w.row_index = i[1:0];
			w.e0 = m[i][0][15:0];
			w.e1 = m[i][1][15:0];
			w.e2 = m[i][2][15:0];
			w.e3 = m[i][3][15:0];
			w.last_row = (i[1:0] == LAST_ROW);
			w.degenerate = degen;
			row_exp_q.push_back(w);
		end
	endtask

	function automatic logic [31:0] rand_coord();
		case ($urandom_range(0, 9))
			0: return 32'h8000_0000;
			1: return 32'h7FFF_FFFF;
			2, 3: return 32'($signed($urandom_range(0, 64)) - 32);
			4, 5: return 32'($signed($urandom_range(0, 1 << 20)) - (1 << 19));
			default: return $urandom;
		endcase
	endfunction

	function automatic pair_t rand_pair();
		pair_t p;
		p.fx = rand_coord(); p.fy = rand_coord(); p.fz = rand_coord();
		p.tx = rand_coord(); p.ty = rand_coord(); p.tz = rand_coord();
		case ($urandom_range(0, 11))
			// coinciding points
			0: begin p.tx = p.fx; p.ty = p.fy; p.tz = p.fz; end
			// direction along one axis only, or zero dx
			1: begin p.ty = p.fy; p.tz = p.fz; end
			2: begin p.tx = p.fx; end
			3: begin p.tx = p.fx; p.ty = p.fy; end
			default: ;
		endcase
		return p;
	endfunction

	function automatic pair_t mk(input int fx, fy, fz, tx, ty, tz);
		pair_t p;
		p.fx = fx; p.fy = fy; p.fz = fz; p.tx = tx; p.ty = ty; p.tz = tz;
		return p;
	endfunction

	// source side: drive at falling edge from the pending queue
	always @(negedge clk) begin
		if (!arst_n) begin
			pts.valid <= 0;
		end else if (!pts.valid || pts_taken) begin
			// pts_taken holds the acceptance seen at the last rising edge
			if (pair_q.size() != 0 && ($urandom_range(0, 5) != 0)) begin
				pair_t p;
				p = pair_q.pop_front();
				pts.valid <= 1;
				pts.from_x <= p.fx; pts.from_y <= p.fy; pts.from_z <= p.fz;
				pts.to_x <= p.tx; pts.to_y <= p.ty; pts.to_z <= p.tz;
			end else begin
				pts.valid <= 0;
			end
		end
	end

	// acceptance of a point word: predict its rows
	always @(posedge clk) begin
		pts_taken = arst_n && pts.valid && pts.ready;
		if (arst_n && pts.valid && pts.ready) begin
			pair_t p;
			p.fx = pts.from_x; p.fy = pts.from_y; p.fz = pts.from_z;
			p.tx = pts.to_x; p.ty = pts.to_y; p.tz = pts.to_z;
			push_matrix_rows(p);
			pairs_sent++;
		end
	end

	// sink side stall pattern
	always @(negedge clk) begin
		if (!arst_n || hold_rows) rows.ready <= 0;
		else rows.ready <= ($urandom_range(0, 3) != 0) ||
			($urandom_range(0, 40) == 0 ? 0 : $urandom_range(0, 1));
	end

	// row monitor
	always @(posedge clk) begin
		cycles++;
		if (arst_n && rows.valid && rows.ready) begin
			row_word_t e;
			rows_seen++;
			if (row_exp_q.size() == 0) begin
				$error("row word with nothing expected");
				errors++;
			end else begin
				e = row_exp_q.pop_front();
				if (rows.degenerate) degen_seen++;
				if (rows.row_index !== e.row_index) begin
					$error("row_index exp %0d got %0d", e.row_index, rows.row_index); errors++;
				end
				if (rows.elem_0 !== e.e0) begin
					$error("elem_0 exp %0d got %0d", $signed(e.e0), rows.elem_0); errors++;
				end
				if (rows.elem_1 !== e.e1) begin
					$error("elem_1 exp %0d got %0d", $signed(e.e1), rows.elem_1); errors++;
				end
				if (rows.elem_2 !== e.e2) begin
					$error("elem_2 exp %0d got %0d", $signed(e.e2), rows.elem_2); errors++;
				end
				if (rows.elem_3 !== e.e3) begin
					$error("elem_3 exp %0d got %0d", $signed(e.e3), rows.elem_3); errors++;
				end
				if (rows.last_row !== e.last_row) begin
					$error("last_row exp %0b got %0b", e.last_row, rows.last_row); errors++;
				end
				if (rows.degenerate !== e.degenerate) begin
					$error("degenerate exp %0b got %0b", e.degenerate, rows.degenerate);
					errors++;
				end
			end
		end
	end

	// watchdog
	always @(posedge clk) begin
		if (cycles > CYCLE_LIMIT) begin
			$display("timeout with %0d rows outstanding", row_exp_q.size());
			$display("Mismatches found");
			$finish;
		end
	end

	// stimulus and end of run
	initial begin
		pts.valid = 0;
		pts.from_x = 0; pts.from_y = 0; pts.from_z = 0;
		pts.to_x = 0; pts.to_y = 0; pts.to_z = 0;
		rows.ready = 0;
		arst_n = 0;
		repeat (4) @(posedge clk);
		@(negedge clk) arst_n = 1;

		// directed: axes, both signs, coinciding points, extremes, zero dx
		pair_q.push_back(mk(0, 0, 0, 0, 0, 0));
		pair_q.push_back(mk(0, 0, 0, 65536, 0, 0));
		pair_q.push_back(mk(0, 0, 0, -65536, 0, 0));
		pair_q.push_back(mk(0, 0, 0, 0, 65536, 0));
		pair_q.push_back(mk(0, 0, 0, 0, -65536, 0));
		pair_q.push_back(mk(0, 0, 0, 0, 0, 65536));
		pair_q.push_back(mk(0, 0, 0, 0, 0, -65536));
		pair_q.push_back(mk(0, 0, 0, 1, 1, 1));
		pair_q.push_back(mk(5, 5, 5, 4, 6, 4));
		pair_q.push_back(mk(32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
			32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF));
		pair_q.push_back(mk(32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF,
			32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000));
		pair_q.push_back(mk(32'h8000_0000, 0, 0, 32'h7FFF_FFFF, 0, 0));
		pair_q.push_back(mk(-1, -1, -1, -1, -1, -1));
		pair_q.push_back(mk(32'h7FFF_FFFF, 0, 0, 32'h7FFF_FFFF, 1, -1));
		pair_q.push_back(mk(0, 0, 0, 3, 4, 0));
		pair_q.push_back(mk(0, 0, 0, -3, -4, 12));
		pair_q.push_back(mk(0, 0, 0, 1, 1000000, 1));

		// long receiver hold while words keep coming
		for (int i = 0; i < 40; i++) pair_q.push_back(rand_pair());
		hold_rows = 1;
		repeat (300) @(posedge clk);
		hold_rows = 0;

		// sender pauses until every expected row is back
		wait (pair_q.size() == 0 && !pts.valid && row_exp_q.size() == 0);

		for (int i = 0; i < 175; i++) begin
			pair_q.push_back(rand_pair());
			if ($urandom_range(0, 30) == 0) repeat ($urandom_range(20, 120)) @(posedge clk);
		end
		wait (pair_q.size() == 0 && !pts.valid);
		stim_done = 1;
		wait (row_exp_q.size() == 0);
		repeat (100) @(posedge clk);

		$display("%0d point words sent, %0d rows checked, %0d degenerate rows",
			pairs_sent, rows_seen, degen_seen);
		if (errors == 0 && row_exp_q.size() == 0) begin
			$display("No mismatches found");
		end else begin
			$display("Mismatches found");
		end
		$finish;
	end
endmodule

### files.f
rtl/omfp_pkg.sv
rtl/omfp_if.sv
rtl/omfp_isqrt.sv
rtl/omfp_div.sv
rtl/orientation_matrix_from_points.sv
dv/orientation_matrix_from_points_tb.sv
